// ===== design/matrix_logical_clock_core_macros.svh =====
// Assertion macros shared by the matrix logical clock RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef MATRIX_LOGICAL_CLOCK_CORE_MACROS_SVH
`define MATRIX_LOGICAL_CLOCK_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLC_ASSERT(label, prop, msg)
`define MLC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/mlc_pkg.sv =====
// Package for the matrix logical clock: sizes, opcodes, states and helpers.
// Used by mlc_store and matrix_logical_clock_core; depends on nothing.
package mlc_pkg;

  localparam int NUM_PROCS = 4;
  localparam int MAX_EMIT  = 16;
  localparam int DEPTH     = NUM_PROCS * NUM_PROCS;
  localparam int EMIT_NUM  = (DEPTH > MAX_EMIT) ? MAX_EMIT : DEPTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PROC_W    = $clog2(NUM_PROCS);

  localparam logic [1:0] OP_LOCAL = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  localparam logic REG_OWN_PROCESS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_EMIT
  } mlc_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
  } mlc_mem_req_t;

  function automatic logic mlc_idx_ok(input logic [1:0] v);
    return 32'(v) < NUM_PROCS;
  endfunction

  function automatic logic [ADDR_W-1:0] mlc_addr(input logic [1:0] r, input logic [1:0] c);
    return ADDR_W'(32'(r) * NUM_PROCS + 32'(c));
  endfunction

endpackage

// ===== design/mlc_store.sv =====
// Clock matrix store: one synchronous memory with per-entry valid bits and
// write-to-read forwarding. Depends on mlc_pkg.
module mlc_store import mlc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mlc_mem_req_t req,
  output logic [31:0]  rd_data
);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      q_r;
  logic [DEPTH-1:0] valid_r;
  logic             vld_q_r;
  logic             fwd_hit_r;
  logic [31:0]      fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r        <= mem[req.rd_addr];
      fwd_data_r <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      vld_q_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r   <= valid_r[req.rd_addr];
        fwd_hit_r <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (vld_q_r ? q_r : 32'd0);

endmodule

// ===== design/matrix_logical_clock_core.sv =====
// Matrix logical clock core: 4x4 matrix of 32-bit counters in one memory.
// A local event bumps the own diagonal entry; a received word raises its entry
// to a larger word value and, if last, also bumps the diagonal; a send bumps
// the diagonal and the (target, own) entry, then emits all 16 entries row-major
// one per cycle, after states FIRST, SECOND and EMIT. A synchronous active-low
// reset clears the matrix and own_process. Needs mlc_pkg, mlc_store, macros.
`include "matrix_logical_clock_core_macros.svh"
module matrix_logical_clock_core import mlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_target,
  input  logic [1:0]  in_elem_row,
  input  logic [1:0]  in_elem_col,
  input  logic [31:0] in_elem_value,
  input  logic        in_elem_last,
  output logic        out_valid,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic [31:0] out_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mlc_state_t        state_r, state_nxt;
  logic [1:0]        own_r;
  logic [1:0]        op_r;
  logic [1:0]        tgt_r;
  logic [31:0]       value_r;
  logic              last_r;
  logic              elem_ok_r;
  logic [ADDR_W-1:0] merge_addr_r;
  logic [ADDR_W-1:0] idx_r;
  logic [PROC_W-1:0] e_row_r, e_col_r;
  logic              emit_v_r;
  logic [PROC_W-1:0] emit_row_r, emit_col_r;
  logic              emit_last_r;
  logic              own_ok;
  logic [ADDR_W-1:0] diag_addr;
  logic [ADDR_W-1:0] sec_addr;
  logic              sec_ok;
  logic              emit_end;
  logic [31:0]       rd_data;
  mlc_mem_req_t      req;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_OWN_PROCESS) ? {30'd0, own_r} : 32'd0;
  assign busy     = (state_r != ST_IDLE);
  assign own_ok   = mlc_idx_ok(own_r);
  assign diag_addr = mlc_addr(own_r, own_r);
  assign sec_addr = (op_r == OP_SEND) ? mlc_addr(tgt_r, own_r) : diag_addr;
  assign sec_ok   = (op_r == OP_SEND) ? (own_ok && mlc_idx_ok(tgt_r)) : own_ok;
  assign emit_end = (idx_r == ADDR_W'(EMIT_NUM - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 2'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_OWN_PROCESS)) begin
      own_r <= pwdata[1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_opcode == OP_LOCAL || in_opcode == OP_SEND ||
                      in_opcode == OP_MERGE)) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (op_r == OP_SEND || (op_r == OP_MERGE && last_r)) begin
          state_nxt = ST_SECOND;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SECOND: begin
        state_nxt = (op_r == OP_SEND) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    unique case (state_r)
      ST_IDLE: begin
        req.rd_en   = start;
        req.rd_addr = (in_opcode == OP_MERGE) ? mlc_addr(in_elem_row, in_elem_col)
                                              : diag_addr;
      end
      ST_FIRST: begin
        req.rd_en   = 1'b1;
        req.rd_addr = sec_addr;
        if (op_r == OP_MERGE) begin
          req.wr_en   = elem_ok_r && (rd_data < value_r);
          req.wr_addr = merge_addr_r;
          req.wr_data = value_r;
        end else begin
          req.wr_en   = own_ok && (op_r == OP_LOCAL || op_r == OP_SEND);
          req.wr_addr = diag_addr;
          req.wr_data = rd_data + 32'd1;
        end
      end
      ST_SECOND: begin
        req.wr_en   = sec_ok;
        req.wr_addr = sec_addr;
        req.wr_data = rd_data + 32'd1;
      end
      ST_EMIT: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx_r;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r         <= in_opcode;
      tgt_r        <= in_target;
      value_r      <= in_elem_value;
      last_r       <= in_elem_last;
      elem_ok_r    <= mlc_idx_ok(in_elem_row) && mlc_idx_ok(in_elem_col);
      merge_addr_r <= mlc_addr(in_elem_row, in_elem_col);
    end
    emit_row_r  <= e_row_r;
    emit_col_r  <= e_col_r;
    emit_last_r <= emit_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      e_row_r  <= '0;
      e_col_r  <= '0;
      emit_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      emit_v_r <= (state_r == ST_EMIT);
      if (state_r == ST_EMIT) begin
        idx_r <= idx_r + ADDR_W'(1);
        if (e_col_r == PROC_W'(NUM_PROCS - 1)) begin
          e_col_r <= '0;
          e_row_r <= e_row_r + PROC_W'(1);
        end else begin
          e_col_r <= e_col_r + PROC_W'(1);
        end
      end else begin
        idx_r   <= '0;
        e_row_r <= '0;
        e_col_r <= '0;
      end
    end
  end

  mlc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign out_valid = emit_v_r;
  assign out_row   = 2'(emit_row_r);
  assign out_col   = 2'(emit_col_r);
  assign out_value = rd_data;
  assign out_last  = emit_v_r && emit_last_r;

  `MLC_ASSERT(a_out_after_emit, out_valid |-> $past(state_r == ST_EMIT), "stray result word")
  `MLC_ASSERT(a_last_marks_end, out_last |-> $past(emit_end), "last word out of place")
  `MLC_ASSERT(a_send_busy, (start && !busy && in_opcode == OP_SEND) |=> busy, "send not taken")
  `MLC_ASSERT_ALWAYS(a_no_out_reset, !rst_n |=> !out_valid, "result word right after reset")

endmodule
